### hw/rtl/pixel_saturation_exposure_adjust_unit_macros.svh
// Assertion macros for the pixel saturation/exposure adjust unit.
// All macros sample on clk and stay quiet while arst_n is low.
`ifndef PIXEL_SATURATION_EXPOSURE_ADJUST_UNIT_MACROS_SVH
`define PIXEL_SATURATION_EXPOSURE_ADJUST_UNIT_MACROS_SVH

// Same-cycle implication.
`define PSEA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psea assertion failed");

// Next-cycle implication.
`define PSEA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psea assertion failed");

`endif

### hw/rtl/psea_pkg.sv
// ----------------------------------------------------------------------------
// psea_pkg
// Shared widths, register codes and the rounding helper for the pixel
// saturation/exposure adjust unit.
// ----------------------------------------------------------------------------
`default_nettype none

package psea_pkg;

	localparam int CB = 8;
	localparam int GB = 16;
	localparam int GF = 12;
	localparam int HF = 16;
	localparam int SW = HF + 1;
	localparam int AW = 33;
	localparam int VXW = CB + GF;
	localparam int PPH = VXW + AW - HF;
	localparam int PPL = VXW + HF;
	localparam int SUMW = PPH + HF + 1;
	localparam int CFG_IW = 8;

	localparam int DIV_STEP = 3;
	localparam int DIV_STAGES = 6;
	localparam int DIV_QW = DIV_STEP * DIV_STAGES;
	localparam int DIV_NW = CB + HF;

	localparam logic [CB-1:0] CMAX = CB'((1 << CB) - 1);
	localparam logic [SW-1:0] SONE = SW'(1 << HF);
	localparam logic [VXW-1:0] VXLIM = VXW'(((1 << CB) - 1) << GF);
	localparam logic [GB-1:0] GAIN_ONE = GB'(1 << GF);

	localparam logic [CFG_IW-1:0] REG_SAT_GAIN = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_EXP_GAIN = CFG_IW'(1);

	localparam logic [2:0] BASE_RED = 3'd0;
	localparam logic [2:0] BASE_GREEN = 3'd2;
	localparam logic [2:0] BASE_BLUE = 3'd4;

	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	typedef struct packed {
		logic [CB-1:0] cmax;
		logic          neg;
		logic [2:0]    base;
		logic          grey;
		logic          fe;
	} side_t;

	// (vx * A + 2^43) >> 44 from the split partial products, clamped.
	function automatic logic [CB-1:0] psea_round(logic [PPH-1:0] hi, logic [PPL-1:0] lo);
		logic [SUMW-1:0] sum;
		logic [SUMW-45:0] r;
		sum = {1'b0, hi, {HF{1'b0}}} + SUMW'(lo) + (SUMW'(1) << 43);
		r = sum[SUMW-1:44];
		return (r > (SUMW-44)'(CMAX)) ? CMAX : r[CB-1:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/psea_div.sv
// ----------------------------------------------------------------------------
// psea_div
// Pipelined restoring divider: round(num * 2^16 / den), three quotient
// bits per stage, one new word per cycle while adv is high.
// ----------------------------------------------------------------------------
`default_nettype none

module psea_div import psea_pkg::*; (
	input  wire logic              clk,
	input  wire logic              adv,
	input  wire logic [CB-1:0]     num,
	input  wire logic [CB-1:0]     den,
	output logic      [DIV_QW-1:0] quo
);

	logic [DIV_NW-1:0] nfull;
	logic [CB-1:0]     rem_s  [DIV_STAGES];
	logic [DIV_QW-1:0] bits_s [DIV_STAGES];
	logic [DIV_QW-1:0] quo_s  [DIV_STAGES];
	logic [CB-1:0]     den_s  [DIV_STAGES];

	assign nfull = {num, {HF{1'b0}}} + DIV_NW'(den >> 1);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [CB-1:0]     rem_i, rem_n;
		logic [DIV_QW-1:0] bits_i, bits_n, quo_i, quo_n;
		logic [CB-1:0]     den_i;
		logic [CB:0]       t;

		if (k == 0) begin : g_first
			assign rem_i  = CB'(nfull[DIV_NW-1:DIV_QW]);
			assign bits_i = nfull[DIV_QW-1:0];
			assign quo_i  = '0;
			assign den_i  = den;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign bits_i = bits_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign den_i  = den_s[k-1];
		end

		always_comb begin
			rem_n  = rem_i;
			bits_n = bits_i;
			quo_n  = quo_i;
			t      = '0;
			for (int j = 0; j < DIV_STEP; j++) begin
				t      = {rem_n, bits_n[DIV_QW-1]};
				bits_n = {bits_n[DIV_QW-2:0], 1'b0};
				if (t >= {1'b0, den_i}) begin
					rem_n = CB'(t - {1'b0, den_i});
					quo_n = {quo_n[DIV_QW-2:0], 1'b1};
				end else begin
					rem_n = t[CB-1:0];
					quo_n = {quo_n[DIV_QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= rem_n;
				bits_s[k] <= bits_n;
				quo_s[k]  <= quo_n;
				den_s[k]  <= den_i;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/pixel_saturation_exposure_adjust_unit.sv
// ----------------------------------------------------------------------------
// pixel_saturation_exposure_adjust_unit
// RGB -> HSV, saturation and exposure gain, HSV -> RGB, one pixel per clock unless held.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | red_in green_in blue_in frame_end_in
// out     | output    | out_valid / out_stall| red_out green_out blue_out frame_end_out
// cfg     | input     | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One pixel per cycle unless held; the stages are the input stage, six divider
// stages for S and hue, then gain, coefficient, multiply and output stages.
// The whole pipeline holds while out_valid and out_stall are both high;
// in_stall follows that hold. Reset clears all valid bits and sets both
// gains to 1.0. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_saturation_exposure_adjust_unit_macros.svh"

module pixel_saturation_exposure_adjust_unit import psea_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CB-1:0]     red_in,
	input  wire logic [CB-1:0]     green_in,
	input  wire logic [CB-1:0]     blue_in,
	input  wire logic              frame_end_in,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [CB-1:0]     red_out,
	output logic      [CB-1:0]     green_out,
	output logic      [CB-1:0]     blue_out,
	output logic                   frame_end_out,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [GB-1:0]     cfg_data
);

	logic          adv;
	logic [GB-1:0] sat_gain_q, exp_gain_q;

	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_gain_q <= GAIN_ONE;
			exp_gain_q <= GAIN_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAT_GAIN: sat_gain_q <= cfg_data;
				REG_EXP_GAIN: exp_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: max/min, hue operands
	logic [CB-1:0] cmx, cmn, pos, ng;
	logic [2:0]    base;

	always_comb begin
		if (red_in >= green_in && red_in >= blue_in) begin
			cmx = red_in; base = BASE_RED; pos = green_in; ng = blue_in;
		end else if (green_in >= blue_in) begin
			cmx = green_in; base = BASE_GREEN; pos = blue_in; ng = red_in;
		end else begin
			cmx = blue_in; base = BASE_BLUE; pos = red_in; ng = green_in;
		end
		cmn = red_in;
		if (green_in < cmn) cmn = green_in;
		if (blue_in < cmn) cmn = blue_in;
	end

	logic          vld_s1;
	logic [CB-1:0] delta_s1, mag_s1;
	side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			delta_s1     <= cmx - cmn;
			mag_s1       <= (pos >= ng) ? pos - ng : ng - pos;
			side_s1.cmax <= cmx;
			side_s1.neg  <= pos < ng;
			side_s1.base <= base;
			side_s1.grey <= cmx == cmn;
			side_s1.fe   <= frame_end_in;
		end
	end

	// divider stages
	logic [DIV_QW-1:0] s_quo, h_quo;
	logic              vld_sd  [DIV_STAGES];
	side_t             side_sd [DIV_STAGES];

	psea_div u_div_s (
		.clk (clk), .adv (adv), .num (delta_s1), .den (side_s1.cmax), .quo (s_quo)
	);

	psea_div u_div_h (
		.clk (clk), .adv (adv), .num (mag_s1), .den (delta_s1), .quo (h_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) vld_sd[i] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= vld_s1;
			for (int i = 1; i < DIV_STAGES; i++) vld_sd[i] <= vld_sd[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= side_s1;
			for (int i = 1; i < DIV_STAGES; i++) side_sd[i] <= side_sd[i-1];
		end
	end

	// stage A: gains, sector and fraction
	side_t              sd_l;
	logic [SW-1:0]      sq, qm;
	logic [SW+GB:0]     sprod;
	logic [SW+GB-GF:0]  ssh;
	logic signed [19:0] hs;
	logic [CB+GB-1:0]   vprod;

	assign sd_l = side_sd[DIV_STAGES-1];

	always_comb begin
		sq    = sd_l.grey ? '0 : s_quo[SW-1:0];
		qm    = h_quo[SW-1:0];
		sprod = (SW+GB+1)'(sq) * (SW+GB+1)'(sat_gain_q) + (SW+GB+1)'(1 << (GF - 1));
		ssh   = sprod[SW+GB:GF];
		hs    = $signed({1'b0, sd_l.base, {HF{1'b0}}});
		if (sd_l.neg) hs = hs - $signed({3'b0, qm});
		else hs = hs + $signed({3'b0, qm});
		if (hs < 0) hs = hs + 20'sd393216;
		vprod = (CB+GB)'(sd_l.cmax) * (CB+GB)'(exp_gain_q);
	end

	logic           vld_a, fe_a;
	logic [SW-1:0]  sat_a;
	logic [2:0]     sec_a;
	logic [HF-1:0]  f_a;
	logic [VXW-1:0] vx_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_a <= 1'b0;
		else if (adv) vld_a <= vld_sd[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_a <= (ssh > (SW+GB-GF+1)'(SONE)) ? SONE : ssh[SW-1:0];
			sec_a <= hs[18:16];
			f_a   <= hs[HF-1:0];
			vx_a  <= (vprod > (CB+GB)'(VXLIM)) ? VXLIM : vprod[VXW-1:0];
			fe_a  <= sd_l.fe;
		end
	end

	// stage B: Q1.32 coefficients
	localparam logic [AW-1:0] A_ONE = AW'(1) << 32;
	logic [AW-1:0] sf;
	logic [AW:0]   st;

	always_comb begin
		sf = AW'(sat_a) * AW'(f_a);
		st = (AW+1)'(sat_a) * (AW+1)'(SONE - SW'(f_a));
	end

	logic           vld_b, fe_b, sz_b;
	logic [AW-1:0]  ap_b, aq_b, at_b;
	logic [2:0]     sec_b;
	logic [VXW-1:0] vx_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_b <= 1'b0;
		else if (adv) vld_b <= vld_a;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ap_b  <= A_ONE - {sat_a, {HF{1'b0}}};
			aq_b  <= A_ONE - sf;
			at_b  <= A_ONE - st[AW-1:0];
			sz_b  <= sat_a == '0;
			sec_b <= sec_a;
			vx_b  <= vx_a;
			fe_b  <= fe_a;
		end
	end

	// stage C: split products
	logic           vld_c, fe_c, sz_c;
	logic [PPH-1:0] ph_p_c, ph_q_c, ph_t_c;
	logic [PPL-1:0] pl_p_c, pl_q_c, pl_t_c;
	logic [2:0]     sec_c;
	logic [CB:0]    av_c;
	logic [VXW:0]   vr;

	assign vr = {1'b0, vx_b} + (VXW+1)'(1 << (GF - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_c <= 1'b0;
		else if (adv) vld_c <= vld_b;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_p_c <= PPH'(vx_b) * PPH'(ap_b[AW-1:HF]);
			ph_q_c <= PPH'(vx_b) * PPH'(aq_b[AW-1:HF]);
			ph_t_c <= PPH'(vx_b) * PPH'(at_b[AW-1:HF]);
			pl_p_c <= PPL'(vx_b) * PPL'(ap_b[HF-1:0]);
			pl_q_c <= PPL'(vx_b) * PPL'(aq_b[HF-1:0]);
			pl_t_c <= PPL'(vx_b) * PPL'(at_b[HF-1:0]);
			av_c   <= vr[VXW:GF];
			sz_c   <= sz_b;
			sec_c  <= sec_b;
			fe_c   <= fe_b;
		end
	end

	// stage D: round, select sector, output register
	logic [CB-1:0] vv, pp, qq, tt, nr, ngr, nb;

	always_comb begin
		vv = (av_c > (CB+1)'(CMAX)) ? CMAX : av_c[CB-1:0];
		pp = psea_round(ph_p_c, pl_p_c);
		qq = psea_round(ph_q_c, pl_q_c);
		tt = psea_round(ph_t_c, pl_t_c);
		case (sec_c)
			SEC_0:   begin nr = vv; ngr = tt; nb = pp; end
			SEC_1:   begin nr = qq; ngr = vv; nb = pp; end
			SEC_2:   begin nr = pp; ngr = vv; nb = tt; end
			SEC_3:   begin nr = pp; ngr = qq; nb = vv; end
			SEC_4:   begin nr = tt; ngr = pp; nb = vv; end
			default: begin nr = vv; ngr = pp; nb = qq; end
		endcase
		if (sz_c) begin
			nr = vv; ngr = vv; nb = vv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_out       <= nr;
			green_out     <= ngr;
			blue_out      <= nb;
			frame_end_out <= fe_c;
		end
	end

	`PSEA_ASSERT_IMP(a_sat_clamped, vld_a, sat_a <= SONE)
	`PSEA_ASSERT_IMP(a_sector_range, vld_a, sec_a <= SEC_5)
	`PSEA_ASSERT_NXT(a_pipe_holds, out_valid && out_stall, $stable(vld_c) && $stable(sec_c))
	`PSEA_ASSERT_NXT(a_out_held, out_valid && out_stall, out_valid && $stable(red_out))

endmodule

`default_nettype wire

### bench/psea_checker.sv
// ----------------------------------------------------------------------------
// psea_checker
// Watches the pixel and register channels of the saturation/exposure adjust
// unit, computes the adjusted pixel for every accepted input word and
// compares each output word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module psea_checker import psea_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_stall,
	input  wire logic [CB-1:0] red_in,
	input  wire logic [CB-1:0] green_in,
	input  wire logic [CB-1:0] blue_in,
	input  wire logic          frame_end_in,
	input  wire logic          out_valid,
	input  wire logic          out_stall,
	input  wire logic [CB-1:0] red_out,
	input  wire logic [CB-1:0] green_out,
	input  wire logic [CB-1:0] blue_out,
	input  wire logic          frame_end_out,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [GB-1:0] cfg_data,
	output int                 fail_count,
	output int                 pending_pixels,
	output int                 checked_pixels
);

	typedef struct packed {
		logic [CB-1:0] r;
		logic [CB-1:0] g;
		logic [CB-1:0] b;
		logic          fe;
	} pixel_t;

	pixel_t adjusted_q[$];
	logic [GB-1:0] sat_gain;
	logic [GB-1:0] exp_gain;

	function automatic logic [CB-1:0] scale_value(logic [63:0] vx, logic [63:0] a);
		logic [63:0] r;
		r = (vx * a + (64'd1 << 43)) >> 44;
		return (r > 64'(CMAX)) ? CMAX : r[CB-1:0];
	endfunction

	function automatic pixel_t adjust_pixel(pixel_t px, logic [GB-1:0] sg, logic [GB-1:0] eg);
		logic [63:0] r, g, b, mx, mn, dl, s, f, sec, pos, neg, base, mag, qm, vx, one;
		longint h;
		logic [CB-1:0] v, p, q, t;
		pixel_t o;
		r = px.r; g = px.g; b = px.b;
		mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
		mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
		dl = mx - mn;
		s = 0; f = 0; sec = 0;
		if (dl > 0) begin
			s = (dl * 65536 + mx / 2) / mx;
			if (mx == r) begin
				base = 0; pos = g; neg = b;
			end else if (mx == g) begin
				base = 2; pos = b; neg = r;
			end else begin
				base = 4; pos = r; neg = g;
			end
			mag = (pos >= neg) ? pos - neg : neg - pos;
			qm = (mag * 65536 + dl / 2) / dl;
			h = longint'(base * 65536);
			if (pos >= neg) h = h + longint'(qm);
			else h = h - longint'(qm);
			if (h < 0) h = h + 6 * 65536;
			sec = 64'(h) >> 16;
			f = 64'(h) & 64'hFFFF;
		end
		s = (s * sg + 2048) >> 12;
		if (s > 65536) s = 65536;
		vx = mx * eg;
		if (vx > 64'(VXLIM)) vx = VXLIM;
		one = 64'd1 << 32;
		v = scale_value(vx, one);
		o.fe = px.fe;
		if (s == 0) begin
			o.r = v; o.g = v; o.b = v;
		end else begin
			p = scale_value(vx, one - s * 65536);
			q = scale_value(vx, one - s * f);
			t = scale_value(vx, one - s * (65536 - f));
			case (sec)
				0: begin o.r = v; o.g = t; o.b = p; end
				1: begin o.r = q; o.g = v; o.b = p; end
				2: begin o.r = p; o.g = v; o.b = t; end
				3: begin o.r = p; o.g = q; o.b = v; end
				4: begin o.r = t; o.g = p; o.b = v; end
				default: begin o.r = v; o.g = p; o.b = q; end
			endcase
		end
		return o;
	endfunction

	assign pending_pixels = adjusted_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t got, exp_px;
		if (!arst_n) begin
			sat_gain <= GAIN_ONE;
			exp_gain <= GAIN_ONE;
			fail_count <= 0;
			checked_pixels <= 0;
			adjusted_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SAT_GAIN) sat_gain <= cfg_data;
				else if (cfg_index == REG_EXP_GAIN) exp_gain <= cfg_data;
			end
			if (in_valid && !in_stall)
				adjusted_q.insert(adjusted_q.size(),
					adjust_pixel({red_in, green_in, blue_in, frame_end_in},
					sat_gain, exp_gain));
			if (out_valid && !out_stall) begin
				got = {red_out, green_out, blue_out, frame_end_out};
				checked_pixels <= checked_pixels + 1;
				if (adjusted_q.size() == 0) begin
					$error("output word with no prediction pending");
					fail_count <= fail_count + 1;
				end else begin
					exp_px = adjusted_q.pop_front();
					if (got != exp_px) fail_count <= fail_count + 1;
					if (got.r != exp_px.r)
						$error("red_out expected %0d got %0d", exp_px.r, got.r);
					if (got.g != exp_px.g)
						$error("green_out expected %0d got %0d", exp_px.g, got.g);
					if (got.b != exp_px.b)
						$error("blue_out expected %0d got %0d", exp_px.b, got.b);
					if (got.fe != exp_px.fe)
						$error("frame_end_out expected %0d got %0d", exp_px.fe, got.fe);
				end
			end
		end
	end

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pixels and gain writes into the saturation/exposure adjust unit
// with random gaps and back-pressure; psea_checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import psea_pkg::*;

	localparam int LATENCY = 11;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CB-1:0] red_in = '0, green_in = '0, blue_in = '0;
	logic frame_end_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CB-1:0] red_out, green_out, blue_out;
	logic frame_end_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [GB-1:0] cfg_data = '0;
	int fail_count, pending_pixels, checked_pixels;
	int cycle_count = 0;
	bit quiet_tail = 1'b0;
	bit long_hold = 1'b0;
	int gain_settings = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pixel_saturation_exposure_adjust_unit uut (.*);

	psea_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// output back-pressure: random bursts, or one long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
				@(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	task automatic write_gain(logic [CFG_IW-1:0] idx, logic [GB-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_pipeline();
		while (pending_pixels != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_gains(logic [GB-1:0] sg, logic [GB-1:0] eg);
		drain_pipeline();
		write_gain(REG_SAT_GAIN, sg);
		write_gain(REG_EXP_GAIN, eg);
		gain_settings++;
	endtask

	task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b,
			logic fe, bit gaps);
		if (gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		frame_end_in <= fe;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(int n);
		logic [CB-1:0] r, g, b;
		for (int i = 0; i < n; i++) begin
			r = CB'($urandom); g = CB'($urandom); b = CB'($urandom);
			case ($urandom_range(0, 7))
				0: begin g = r; b = r; end
				1: g = r;
				2: b = g;
				3: begin r = 8'd255; b = 8'd0; end
				default: ;
			endcase
			send_pixel(r, g, b, $urandom_range(0, 7) == 0, 1'b1);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, greys, ties, every hue sector, wrap of negative hue
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255, 1'b0, 1'b0);
		send_pixel(8'd200, 8'd10, 8'd90, 1'b0, 1'b0);
		send_pixel(8'd200, 8'd120, 8'd10, 1'b0, 1'b0);
		send_pixel(8'd40, 8'd200, 8'd10, 1'b0, 1'b0);
		send_pixel(8'd10, 8'd200, 8'd150, 1'b0, 1'b0);
		send_pixel(8'd60, 8'd10, 8'd200, 1'b0, 1'b0);
		send_pixel(8'd200, 8'd200, 8'd200, 1'b1, 1'b0);
		send_pixel(8'd1, 8'd0, 8'd0, 1'b0, 1'b0);
		send_pixel(8'd170, 8'd85, 8'd170, 1'b1, 1'b0);
		in_valid <= 1'b0;

		// sender waits for every pending result
		drain_pipeline();

		// gain sweep including extremes and an out-of-range register index
		set_gains(16'd0, 16'd0);
		send_random(40);
		set_gains(16'hFFFF, 16'hFFFF);
		send_random(40);
		drain_pipeline();
		write_gain(CFG_IW'(2), 16'd0);
		send_random(20);
		set_gains(16'd2048, 16'd8192);
		send_random(60);

		// long receiver hold while the sender keeps offering
		set_gains(16'd6000, 16'd3000);
		long_hold = 1'b1;
		send_random(80);

		for (int k = 0; k < 6; k++) begin
			set_gains(GB'($urandom), GB'($urandom_range(0, 12000)));
			send_random(70);
		end

		set_gains(GAIN_ONE, GAIN_ONE);
		quiet_tail = 1'b1;
		send_random(60);

		drain_pipeline();
		$display("covered %0d output pixels over %0d gain settings", checked_pixels,
			gain_settings);
		if (fail_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/psea_pkg.sv
hw/rtl/psea_div.sv
hw/rtl/pixel_saturation_exposure_adjust_unit.sv
bench/psea_checker.sv
bench/testbench.sv
